// File: design/stsol_pkg.sv
// Shared constants and codes for the simplex tableau solver.
package stsol_pkg;

    localparam int DEF_MAX_CONSTRAINTS = 8;
    localparam int DEF_MAX_COLUMNS     = 32;
    localparam int DEF_FRAC_BITS       = 16;
    localparam int VAL_W               = 32;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_SOLVE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] ST_READ       = 3'd0;
    localparam logic [2:0] ST_OPTIMAL    = 3'd1;
    localparam logic [2:0] ST_UNBOUNDED  = 3'd2;
    localparam logic [2:0] ST_ITER_LIMIT = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    localparam logic [1:0] CFG_NUM_CONS = 2'd0;
    localparam logic [1:0] CFG_NUM_VARS = 2'd1;
    localparam logic [1:0] CFG_MAX_PIV  = 2'd2;

    function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] v);
        abs_val = v[VAL_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: design/simplex_tableau_solver_core.sv
// Simplex tableau solver top level: tableau memories, pivot sequencer, divider.
//
//  channel   | dir | beat contents
//  s_axis    | in  | tuser req_type; tdata row, col, value
//  m_axis    | out | tuser status; tdata result_value, pivot_count
//  apb       | cfg | num_constraints @0x0, num_vars @0x4, max_pivots @0x8
//
// Write beats are written as accepted; read beats wait on the registered memory read.
// The divider runs NB = 32+FRAC_BITS quotient steps per division.
// Reset is synchronous; tableau contents are undefined until written.
// The result register holds m_axis results; while it is full and m_axis stalls, s_axis_tready is low.
module simplex_tableau_solver_core #(
    parameter int MAX_CONSTRAINTS = stsol_pkg::DEF_MAX_CONSTRAINTS,
    parameter int MAX_COLUMNS     = stsol_pkg::DEF_MAX_COLUMNS,
    parameter int FRAC_BITS       = stsol_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,  // row[3:0] col[8:4] value[40:9]
    input  logic [1:0]                  s_axis_tuser,  // req_type[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,  // result_value[31:0] pivot_count[39:32]
    output logic [2:0]                  m_axis_tuser,  // status[2:0]
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stsol_pkg::APB_AW-1:0] paddr,
    input  logic [stsol_pkg::APB_DW-1:0] pwdata,
    output logic [stsol_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int VW    = stsol_pkg::VAL_W;
    localparam int NROWS = MAX_CONSTRAINTS + 1;
    localparam int DEPTH = NROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(NROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int NB    = VW + FRAC_BITS;
    localparam int DCW   = $clog2(NB + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_ENT_RD, S_ENT_CMP, S_ENT_DEC, S_RAT_RD, S_RAT_CHK, S_RAT_DIV,
        S_RAT_DEC, S_PIV_P, S_PRW_RD, S_PRW_DIV0, S_PRW_DIV, S_ELM_ROW, S_ELM_F,
        S_ELM_RD, S_ELM_MUL, S_ELM_SUB, S_PIV_END, S_FIN_RD, S_FIN
    } t_state;

    t_state r_state;

    logic [3:0]    r_num_cons;
    logic [4:0]    r_num_vars;
    logic [7:0]    r_max_piv;
    logic [7:0]    r_pivots;
    logic [CW-1:0] r_ent_col;
    logic [RW-1:0] r_leave_row;
    logic [RW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [VW-1:0] r_best;
    logic [VW-1:0] r_bq;
    logic          r_found;
    logic [VW-1:0] r_piv;
    logic [VW-1:0] r_f;
    logic          r_ovf;
    logic [2:0]    r_status;
    logic [63:0]   r_prod;
    logic          r_mneg;
    logic [VW-1:0] r_cij;
    logic          r_rd_pend;
    logic          r_rd_inside;

    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [VW-1:0] r_out_value;
    logic [7:0]    r_out_cnt;

    logic           r_dv_busy;
    logic [DCW-1:0] r_dv_cnt;
    logic [NB-1:0]  r_dv_num;
    logic [VW:0]    r_dv_rem;
    logic [VW-1:0]  r_dv_den;
    logic           r_dv_neg;

    // host beat fields
    logic [1:0]    in_type;
    logic [3:0]    in_row;
    logic [4:0]    in_col;
    logic [VW-1:0] in_value;
    logic          in_inside;
    logic          in_acc;
    logic          out_free;
    logic          out_load;

    assign in_type  = s_axis_tuser;
    assign in_row   = s_axis_tdata[3:0];
    assign in_col   = s_axis_tdata[8:4];
    assign in_value = s_axis_tdata[40:9];
    assign in_inside = (32'(in_row) < NROWS) && (32'(in_col) < MAX_COLUMNS);

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_rd_pend && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // effective geometry
    logic [RW-1:0] nc;
    logic [5:0]    nv;
    logic [7:0]    ncols_sum;
    logic [CW-1:0] rhs;

    always_comb begin
        if (r_num_cons == 4'd0) begin
            nc = RW'(1);
        end else if (32'(r_num_cons) > MAX_CONSTRAINTS) begin
            nc = RW'(MAX_CONSTRAINTS);
        end else begin
            nc = RW'(r_num_cons);
        end
        nv = (r_num_vars == 5'd0) ? 6'd1 : 6'(r_num_vars);
        ncols_sum = 8'(nv) + 8'(nc) + 8'd1;
        if (32'(ncols_sum) > MAX_COLUMNS) begin
            ncols_sum = 8'(MAX_COLUMNS);
        end
        rhs = CW'(ncols_sum - 8'd1);
    end

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_COLUMNS + 32'(c));
    endfunction

    // memories: two copies written together, one read port each
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [AW-1:0] ra_a;
    logic [AW-1:0] ra_b;
    logic [VW-1:0] qa;
    logic [VW-1:0] qb;

    stsol_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(ra_a), .o_rdata(qa)
    );

    stsol_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(ra_b), .o_rdata(qb)
    );

    // divider: restoring, one quotient bit per cycle
    logic           dv_done;
    logic [VW:0]    dv_rem_sh;
    logic           dv_ge;
    logic [NB-1:0]  dv_lim;
    logic           dv_sat;
    logic [VW-1:0]  dv_mag;
    logic [VW-1:0]  dv_res;
    logic           dv_start;
    logic [VW-1:0]  dv_n;
    logic [VW-1:0]  dv_d;

    assign dv_done   = r_dv_busy && (r_dv_cnt == '0);
    assign dv_rem_sh = {r_dv_rem[VW-1:0], r_dv_num[NB-1]};
    assign dv_ge     = dv_rem_sh >= {1'b0, r_dv_den};
    assign dv_lim    = r_dv_neg ? (NB'(1) << (VW - 1)) : ((NB'(1) << (VW - 1)) - NB'(1));
    assign dv_sat    = r_dv_num > dv_lim;
    assign dv_mag    = dv_sat ? dv_lim[VW-1:0] : r_dv_num[VW-1:0];
    assign dv_res    = r_dv_neg ? (~dv_mag + 1'b1) : dv_mag;

    // product and difference
    logic [63:0]   mul_res;
    logic [63:0]   m_sh;
    logic [63:0]   m_lim;
    logic          m_sat;
    logic [VW-1:0] m_mag;
    logic [VW-1:0] m_val;
    logic [VW:0]   diff;
    logic          d_sat;
    logic [VW-1:0] d_res;

    assign mul_res = stsol_pkg::abs_val(qb) * stsol_pkg::abs_val(r_f);
    assign m_sh    = r_prod >> FRAC_BITS;
    assign m_lim   = r_mneg ? (64'd1 << (VW - 1)) : ((64'd1 << (VW - 1)) - 64'd1);
    assign m_sat   = m_sh > m_lim;
    assign m_mag   = m_sat ? m_lim[VW-1:0] : m_sh[VW-1:0];
    assign m_val   = r_mneg ? (~m_mag + 1'b1) : m_mag;
    assign diff    = {r_cij[VW-1], r_cij} - {m_val[VW-1], m_val};
    assign d_sat   = diff[VW] != diff[VW-1];
    assign d_res   = d_sat ? (diff[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                           : diff[VW-1:0];

    always_comb begin
        ra_a = cell_addr(RW'(in_row), CW'(in_col));
        ra_b = ra_a;
        unique case (r_state)
            S_ENT_RD: ra_a = cell_addr(nc, r_j);
            S_RAT_RD: begin
                ra_a = cell_addr(r_i, r_ent_col);
                ra_b = cell_addr(r_i, rhs);
            end
            S_RAT_DEC: ra_a = cell_addr(r_leave_row, r_ent_col);
            S_PRW_RD:  ra_a = cell_addr(r_leave_row, r_j);
            S_ELM_ROW: ra_a = cell_addr(r_i, r_ent_col);
            S_ELM_RD: begin
                ra_a = cell_addr(r_i, r_j);
                ra_b = cell_addr(r_leave_row, r_j);
            end
            S_FIN_RD, S_FIN: ra_a = cell_addr(nc, rhs);
            default: ;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = cell_addr(RW'(in_row), CW'(in_col));
        wdata = in_value;
        if (r_state == S_IDLE) begin
            we = in_acc && (in_type == stsol_pkg::REQ_WRITE) && in_inside;
        end else if (r_state == S_PRW_DIV) begin
            we    = dv_done;
            waddr = cell_addr(r_leave_row, r_j);
            wdata = dv_res;
        end else if (r_state == S_ELM_SUB) begin
            we    = 1'b1;
            waddr = cell_addr(r_i, r_j);
            wdata = d_res;
        end
    end

    always_comb begin
        dv_start = 1'b0;
        dv_n     = qa;
        dv_d     = r_piv;
        if (r_state == S_RAT_CHK) begin
            dv_start = !qa[VW-1] && (qa != '0);
            dv_n     = qb;
            dv_d     = qa;
        end else if (r_state == S_PRW_DIV0) begin
            dv_start = 1'b1;
        end
    end

    assign out_load = (r_rd_pend) || ((r_state == S_FIN) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_cons  <= 4'd1;
            r_num_vars  <= 5'd1;
            r_max_piv   <= 8'd64;
            r_pivots    <= 8'd0;
            r_ent_col   <= '0;
            r_leave_row <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_dv_busy   <= 1'b0;
            r_dv_cnt    <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    stsol_pkg::CFG_NUM_CONS: r_num_cons <= pwdata[3:0];
                    stsol_pkg::CFG_NUM_VARS: r_num_vars <= pwdata[4:0];
                    stsol_pkg::CFG_MAX_PIV:  r_max_piv  <= pwdata[7:0];
                    default: ;
                endcase
            end

            if (dv_start) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt  <= DCW'(NB);
                r_dv_num  <= {stsol_pkg::abs_val(dv_n), {FRAC_BITS{1'b0}}};
                r_dv_rem  <= '0;
                r_dv_den  <= stsol_pkg::abs_val(dv_d);
                r_dv_neg  <= dv_n[VW-1] != dv_d[VW-1];
            end else if (r_dv_busy && (r_dv_cnt != '0)) begin
                r_dv_cnt <= r_dv_cnt - 1'b1;
                r_dv_num <= {r_dv_num[NB-2:0], dv_ge};
                r_dv_rem <= dv_ge ? (dv_rem_sh - {1'b0, r_dv_den}) : dv_rem_sh;
            end else if (dv_done && (r_state == S_RAT_DIV || r_state == S_PRW_DIV)) begin
                r_dv_busy <= 1'b0;
            end

            r_rd_pend <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_rd_pend) begin
                r_out_status <= stsol_pkg::ST_READ;
                r_out_value  <= r_rd_inside ? qa : '0;
                r_out_cnt    <= r_pivots;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_type == stsol_pkg::REQ_SOLVE) begin
                            r_pivots <= 8'd0;
                            r_ovf    <= 1'b0;
                            r_j      <= '0;
                            r_state  <= S_ENT_RD;
                        end else if (in_type == stsol_pkg::REQ_READ) begin
                            r_rd_pend   <= 1'b1;
                            r_rd_inside <= in_inside;
                        end
                    end
                end
                S_ENT_RD: r_state <= S_ENT_CMP;
                S_ENT_CMP: begin
                    if ((r_j == '0) || ($signed(qa) < $signed(r_best))) begin
                        r_best    <= qa;
                        r_ent_col <= r_j;
                    end
                    if (r_j == rhs - 1'b1) begin
                        r_state <= S_ENT_DEC;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ENT_RD;
                    end
                end
                S_ENT_DEC: begin
                    if (!r_best[VW-1]) begin
                        r_status <= stsol_pkg::ST_OPTIMAL;
                        r_state  <= S_FIN_RD;
                    end else if (r_pivots >= r_max_piv) begin
                        r_status <= stsol_pkg::ST_ITER_LIMIT;
                        r_state  <= S_FIN_RD;
                    end else begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_RAT_RD;
                    end
                end
                S_RAT_RD: r_state <= S_RAT_CHK;
                S_RAT_CHK: begin
                    if (dv_start) begin
                        r_state <= S_RAT_DIV;
                    end else if (r_i == nc - 1'b1) begin
                        r_state <= S_RAT_DEC;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RAT_RD;
                    end
                end
                S_RAT_DIV: begin
                    if (dv_done) begin
                        if (!r_found || ($signed(dv_res) < $signed(r_bq))) begin
                            r_found     <= 1'b1;
                            r_bq        <= dv_res;
                            r_leave_row <= r_i;
                        end
                        if (r_i == nc - 1'b1) begin
                            r_state <= S_RAT_DEC;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RAT_RD;
                        end
                    end
                end
                S_RAT_DEC: begin
                    if (!r_found) begin
                        r_status <= stsol_pkg::ST_UNBOUNDED;
                        r_state  <= S_FIN_RD;
                    end else begin
                        r_state <= S_PIV_P;
                    end
                end
                S_PIV_P: begin
                    r_piv   <= qa;
                    r_j     <= '0;
                    r_state <= S_PRW_RD;
                end
                S_PRW_RD:   r_state <= S_PRW_DIV0;
                S_PRW_DIV0: r_state <= S_PRW_DIV;
                S_PRW_DIV: begin
                    if (dv_done) begin
                        r_ovf <= r_ovf | dv_sat;
                        if (r_j == rhs) begin
                            r_i     <= '0;
                            r_state <= S_ELM_ROW;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_PRW_RD;
                        end
                    end
                end
                S_ELM_ROW: begin
                    if (r_i == r_leave_row) begin
                        if (r_i == nc) begin
                            r_state <= S_PIV_END;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_state <= S_ELM_F;
                    end
                end
                S_ELM_F: begin
                    r_f <= qa;
                    r_j <= '0;
                    if (qa != '0) begin
                        r_state <= S_ELM_RD;
                    end else if (r_i == nc) begin
                        r_state <= S_PIV_END;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ELM_ROW;
                    end
                end
                S_ELM_RD: r_state <= S_ELM_MUL;
                S_ELM_MUL: begin
                    r_prod  <= mul_res;
                    r_mneg  <= qb[VW-1] != r_f[VW-1];
                    r_cij   <= qa;
                    r_state <= S_ELM_SUB;
                end
                S_ELM_SUB: begin
                    r_ovf <= r_ovf | m_sat | d_sat;
                    if (r_j != rhs) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ELM_RD;
                    end else if (r_i == nc) begin
                        r_state <= S_PIV_END;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ELM_ROW;
                    end
                end
                S_PIV_END: begin
                    r_pivots <= r_pivots + 1'b1;
                    if (r_ovf) begin
                        r_status <= stsol_pkg::ST_OVERFLOW;
                        r_state  <= S_FIN_RD;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_ENT_RD;
                    end
                end
                S_FIN_RD: r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_value  <= qa;
                        r_out_cnt    <= r_pivots;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_cnt, r_out_value};
    assign m_axis_tuser  = r_out_status;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            stsol_pkg::CFG_NUM_CONS: prdata = {28'd0, r_num_cons};
            stsol_pkg::CFG_NUM_VARS: prdata = {27'd0, r_num_vars};
            stsol_pkg::CFG_MAX_PIV:  prdata = {24'd0, r_max_piv};
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: design/stsol_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stsol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 288
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
